/* sv/pfvc_pkg.sv */
// types, constants and microcode table shared by the velocity controller
package pfvc_pkg;

    localparam int VEL_W    = 16;
    localparam int ERR_W    = 17;
    localparam int DIFF_W   = 18;
    localparam int MAG_W    = 17;
    localparam int DT_W     = 20;
    localparam int STAT_W   = 8;
    localparam int ACC32_W  = 32;
    localparam int TERM_W   = 32;
    localparam int PROD_W   = VEL_W + TERM_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int FRAC_W   = 8;
    localparam int DIV_W    = MAG_W + DT_W;
    localparam int STEP_W   = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [DT_W-1:0] US_PER_SECOND = DT_W'(1000000);

    localparam logic [1:0] OP_MEASURED = 2'd0;
    localparam logic [1:0] OP_TARGET   = 2'd1;
    localparam logic [1:0] OP_STATUS   = 2'd2;

    localparam logic signed [STAT_W-1:0] DISABLE_STATUS = 8'sd2;

    localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd5;

    localparam logic signed [VEL_W-1:0] KP_RESET      = 16'sd2560;
    localparam logic signed [VEL_W-1:0] KI_RESET      = 16'sd0;
    localparam logic signed [VEL_W-1:0] KD_RESET      = 16'sd0;
    localparam logic signed [VEL_W-1:0] KF_RESET      = 16'sd256;
    localparam logic signed [VEL_W-1:0] CEILING_RESET = 16'sd12800;
    localparam logic signed [VEL_W-1:0] FLOOR_RESET   = 16'sd0;
    localparam logic signed [VEL_W-1:0] TARGET_RESET  = 16'sd512;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [VEL_W-1:0]  velocity_value;
        logic [DT_W-1:0]          elapsed_us;
        logic signed [STAT_W-1:0] status_code;
    } in_item_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] throttle_command;
        logic                    updated;
    } out_item_t;

    typedef enum logic [3:0] {
        U_LOAD,
        U_ERR,
        U_SCALE,
        U_DIV_GO,
        U_NOP,
        U_RATE,
        U_MUL,
        U_ADD,
        U_CLAMP,
        U_EMIT
    } uop_t;

    typedef enum logic [1:0] {
        T_PROP,
        T_INTEG,
        T_DERIV,
        T_FEED
    } term_sel_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_WAIT_IN,
        J_SKIP,
        J_WAIT_DIV,
        J_WAIT_OUT
    } jump_t;

    typedef struct packed {
        uop_t              uop;
        term_sel_t         sel;
        jump_t             jump;
        logic [STEP_W-1:0] target;
    } ctl_word_t;

    localparam logic [STEP_W-1:0] S_WAIT = 4'd0;
    localparam logic [STEP_W-1:0] S_EMIT = 4'd15;

    function automatic ctl_word_t microcode(input logic [STEP_W-1:0] step);
        ctl_word_t cw;
        cw = '{U_NOP, T_PROP, J_NEXT, S_WAIT};
        case (step)
            4'd0:  cw = '{U_LOAD,   T_PROP,  J_WAIT_IN,  S_WAIT};
            4'd1:  cw = '{U_ERR,    T_PROP,  J_SKIP,     S_EMIT};
            4'd2:  cw = '{U_SCALE,  T_PROP,  J_NEXT,     S_WAIT};
            4'd3:  cw = '{U_DIV_GO, T_PROP,  J_NEXT,     S_WAIT};
            4'd4:  cw = '{U_NOP,    T_PROP,  J_WAIT_DIV, S_WAIT};
            4'd5:  cw = '{U_RATE,   T_PROP,  J_NEXT,     S_WAIT};
            4'd6:  cw = '{U_MUL,    T_PROP,  J_NEXT,     S_WAIT};
            4'd7:  cw = '{U_ADD,    T_PROP,  J_NEXT,     S_WAIT};
            4'd8:  cw = '{U_MUL,    T_INTEG, J_NEXT,     S_WAIT};
            4'd9:  cw = '{U_ADD,    T_INTEG, J_NEXT,     S_WAIT};
            4'd10: cw = '{U_MUL,    T_DERIV, J_NEXT,     S_WAIT};
            4'd11: cw = '{U_ADD,    T_DERIV, J_NEXT,     S_WAIT};
            4'd12: cw = '{U_MUL,    T_FEED,  J_NEXT,     S_WAIT};
            4'd13: cw = '{U_ADD,    T_FEED,  J_NEXT,     S_WAIT};
            4'd14: cw = '{U_CLAMP,  T_PROP,  J_NEXT,     S_WAIT};
            4'd15: cw = '{U_EMIT,   T_PROP,  J_WAIT_OUT, S_WAIT};
            default: cw = '{U_NOP,  T_PROP,  J_NEXT,     S_WAIT};
        endcase
        return cw;
    endfunction

endpackage

/* sv/pfvc_div.sv */
// restoring unsigned divider, one quotient bit per cycle
module pfvc_div
    import pfvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DT_W-1:0]  divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DT_W-1:0]  rem_reg;
    logic [DT_W-1:0]  den_reg;
    logic [DT_W:0]    trial;
    logic             fits;
    logic [DT_W:0]    trial_sub;

    assign trial     = {rem_reg, quo_reg[DIV_W-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == CNT_W'(DIV_W - 1))
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* sv/pid_feedforward_velocity_controller.sv */
// velocity controller top level: microcoded pid with feedforward and clamp
//
// Each item is a measured velocity, a target velocity or a status event, and
// gives one result. An item that recomputes the command holds off the next
// item until its result is emitted, mostly while the restoring divider
// forms the error rate; the remaining steps of the 16-step microprogram do
// the error update, four multiply-accumulates and the clamp. Other items
// skip the arithmetic. The result sits in an output register, so the
// next item can be taken while it waits. Configuration writes are taken at
// any time but belong in idle periods.
module pid_feedforward_velocity_controller
    import pfvc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VEL_W-1:0]     cfg_data
);

    localparam int SH_W = ACC_W - FRAC_W;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ctl_word_t         cw;

    logic signed [VEL_W-1:0] kp_reg, ki_reg, kd_reg, kf_reg;
    logic signed [VEL_W-1:0] ceiling_reg, floor_reg;

    logic signed [VEL_W-1:0]   target_reg;
    logic signed [VEL_W-1:0]   measured_reg;
    logic signed [ERR_W-1:0]   last_error_reg;
    logic signed [ACC32_W-1:0] error_sum_reg;
    logic signed [ACC32_W-1:0] error_rate_reg;
    logic                      loop_en_reg;
    logic signed [VEL_W-1:0]   held_reg;
    logic                      upd_reg;
    logic [DT_W-1:0]           dt_reg;

    logic signed [ERR_W-1:0] err_reg;
    logic                    neg_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [DIV_W-1:0]        dividend_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    logic                  accept;
    logic                  emit_ok;
    logic                  div_start;
    logic                  div_busy;
    logic [DIV_W-1:0]      div_quo;

    logic signed [ERR_W-1:0]    err_calc;
    logic signed [DIFF_W-1:0]   diff_calc;
    logic [DIFF_W-1:0]          diff_abs;
    logic signed [ACC32_W:0]    sum_wide;
    logic signed [ACC32_W-1:0]  sum_sat;
    logic signed [ACC32_W-1:0]  rate_sat;
    logic signed [VEL_W-1:0]    mul_a;
    logic signed [TERM_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [SH_W-1:0]     shifted;
    logic signed [SH_W-1:0]     capped;
    logic signed [SH_W-1:0]     clamped;

    assign cw        = microcode(step_reg);
    assign in_ready  = (cw.jump == J_WAIT_IN);
    assign accept    = in_valid && in_ready;
    assign emit_ok   = !out_valid_reg || out_ready;
    assign div_start = (cw.uop == U_DIV_GO);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    pfvc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_reg),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // sequencer
    always_comb
    begin
        step_next = step_reg + 1'b1;
        unique case (cw.jump)
            J_NEXT:     step_next = step_reg + 1'b1;
            J_WAIT_IN:  step_next = accept ? step_reg + 1'b1 : step_reg;
            J_SKIP:     step_next = upd_reg ? step_reg + 1'b1 : cw.target;
            J_WAIT_DIV: step_next = div_busy ? step_reg : step_reg + 1'b1;
            J_WAIT_OUT: step_next = emit_ok ? cw.target : step_reg;
            default:    step_next = step_reg + 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= S_WAIT;
        else
            step_reg <= step_next;
    end

    // datapath arithmetic
    always_comb
    begin
        err_calc  = ERR_W'(target_reg) - ERR_W'(measured_reg);
        diff_calc = DIFF_W'(err_calc) - DIFF_W'(last_error_reg);
        diff_abs  = diff_calc[DIFF_W-1] ? DIFF_W'(-diff_calc) : DIFF_W'(diff_calc);

        sum_wide = (ACC32_W+1)'(error_sum_reg) + (ACC32_W+1)'(err_reg);
        if (sum_wide[ACC32_W] != sum_wide[ACC32_W-1])
            sum_sat = sum_wide[ACC32_W] ? {1'b1, {(ACC32_W-1){1'b0}}}
                                        : {1'b0, {(ACC32_W-1){1'b1}}};
        else
            sum_sat = sum_wide[ACC32_W-1:0];

        if (!neg_reg)
            rate_sat = (div_quo > DIV_W'({1'b0, {(ACC32_W-1){1'b1}}}))
                     ? {1'b0, {(ACC32_W-1){1'b1}}} : div_quo[ACC32_W-1:0];
        else
            rate_sat = (div_quo > DIV_W'({1'b1, {(ACC32_W-1){1'b0}}}))
                     ? {1'b1, {(ACC32_W-1){1'b0}}} : -div_quo[ACC32_W-1:0];

        case (cw.sel)
            T_PROP:
            begin
                mul_a = kp_reg;
                mul_b = TERM_W'(last_error_reg);
            end
            T_INTEG:
            begin
                mul_a = ki_reg;
                mul_b = error_sum_reg;
            end
            T_DERIV:
            begin
                mul_a = kd_reg;
                mul_b = error_rate_reg;
            end
            default:
            begin
                mul_a = kf_reg;
                mul_b = TERM_W'(target_reg);
            end
        endcase
        mul_p = mul_a * mul_b;

        shifted = SH_W'(acc_reg >>> FRAC_W);
        capped  = (shifted > SH_W'(ceiling_reg)) ? SH_W'(ceiling_reg) : shifted;
        clamped = (capped < SH_W'(floor_reg)) ? SH_W'(floor_reg) : capped;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg      <= KP_RESET;
            ki_reg      <= KI_RESET;
            kd_reg      <= KD_RESET;
            kf_reg      <= KF_RESET;
            ceiling_reg <= CEILING_RESET;
            floor_reg   <= FLOOR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KP:      kp_reg      <= cfg_data;
                REG_KI:      ki_reg      <= cfg_data;
                REG_KD:      kd_reg      <= cfg_data;
                REG_KF:      kf_reg      <= cfg_data;
                REG_CEILING: ceiling_reg <= cfg_data;
                REG_FLOOR:   floor_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= TARGET_RESET;
            measured_reg   <= '0;
            last_error_reg <= '0;
            error_sum_reg  <= '0;
            error_rate_reg <= '0;
            loop_en_reg    <= 1'b1;
            held_reg       <= '0;
            upd_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cw.uop == U_EMIT && emit_ok)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (cw.uop)
                U_LOAD:
                begin
                    if (accept)
                    begin
                        if (in_data.opcode == OP_MEASURED)
                            measured_reg <= in_data.velocity_value;
                        if (in_data.opcode == OP_TARGET)
                            target_reg <= in_data.velocity_value;
                        if (in_data.opcode == OP_STATUS
                            && in_data.status_code == DISABLE_STATUS)
                            loop_en_reg <= 1'b0;
                        upd_reg <= (in_data.opcode == OP_MEASURED
                                    || in_data.opcode == OP_TARGET)
                                   && loop_en_reg && (in_data.elapsed_us != '0);
                    end
                end
                U_RATE:
                begin
                    error_rate_reg <= rate_sat;
                    error_sum_reg  <= sum_sat;
                    last_error_reg <= err_reg;
                end
                U_CLAMP:
                    held_reg <= clamped[VEL_W-1:0];
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (cw.uop)
            U_LOAD:
                if (accept)
                    dt_reg <= in_data.elapsed_us;
            U_ERR:
            begin
                err_reg <= err_calc;
                neg_reg <= diff_calc[DIFF_W-1];
                mag_reg <= diff_abs[MAG_W-1:0];
            end
            U_SCALE:
                dividend_reg <= DIV_W'(mag_reg) * DIV_W'(US_PER_SECOND);
            U_RATE:
                acc_reg <= '0;
            U_MUL:
                prod_reg <= mul_p;
            U_ADD:
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            U_EMIT:
                if (emit_ok)
                begin
                    out_data_reg.throttle_command <= held_reg;
                    out_data_reg.updated          <= upd_reg;
                end
            default: ;
        endcase
    end

endmodule

/* test/testbench.sv */
// testbench for the pid feedforward velocity controller: scoreboard, stimulus and checks
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pfvc_pkg::*;

    localparam logic [1:0]           OP_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
    localparam int                   CYCLE_LIMIT   = 1000000;
    localparam int                   PHASE_ITEMS   = 220;
    localparam int                   DRAIN_CYCLES  = 64;

    class command_scoreboard;
        logic signed [VEL_W-1:0] gain_p;
        logic signed [VEL_W-1:0] gain_i;
        logic signed [VEL_W-1:0] gain_d;
        logic signed [VEL_W-1:0] gain_f;
        logic signed [VEL_W-1:0] cmd_ceiling;
        logic signed [VEL_W-1:0] cmd_floor;
        logic signed [VEL_W-1:0] target_vel;
        logic signed [VEL_W-1:0] measured_vel;
        logic signed [VEL_W-1:0] held_cmd;
        logic signed [ERR_W-1:0] prev_error;
        logic signed [31:0]      error_total;
        bit                      loop_on;
        out_item_t               expected_commands[$];
        int                      failures;

        function new();
            gain_p       = KP_RESET;
            gain_i       = KI_RESET;
            gain_d       = KD_RESET;
            gain_f       = KF_RESET;
            cmd_ceiling  = CEILING_RESET;
            cmd_floor    = FLOOR_RESET;
            target_vel   = TARGET_RESET;
            measured_vel = '0;
            held_cmd     = '0;
            prev_error   = '0;
            error_total  = '0;
            loop_on      = 1'b1;
            failures     = 0;
        endfunction

        function int pending();
            return expected_commands.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [VEL_W-1:0] val);
            case (idx)
                REG_KP:      gain_p = val;
                REG_KI:      gain_i = val;
                REG_KD:      gain_d = val;
                REG_KF:      gain_f = val;
                REG_CEILING: cmd_ceiling = val;
                REG_FLOOR:   cmd_floor = val;
                default:     ;
            endcase
        endfunction

        function longint saturate32(longint x);
            if (x > 64'sd2147483647)
                return 64'sd2147483647;
            if (x < -64'sd2147483648)
                return -64'sd2147483648;
            return x;
        endfunction

        // works out the command that an accepted item should produce
        function void note_item(in_item_t it);
            out_item_t res;
            longint    err;
            longint    slope;
            longint    total;
            longint    acc;
            longint    dt;
            if (it.opcode == OP_MEASURED)
                measured_vel = it.velocity_value;
            else if (it.opcode == OP_TARGET)
                target_vel = it.velocity_value;
            else if (it.opcode == OP_STATUS && it.status_code == DISABLE_STATUS)
                loop_on = 1'b0;
            res.updated = 1'b0;
            if ((it.opcode == OP_MEASURED || it.opcode == OP_TARGET) && loop_on
                && it.elapsed_us != '0)
            begin
                dt    = longint'(it.elapsed_us);
                err   = longint'(target_vel) - longint'(measured_vel);
                slope = saturate32(((err - longint'(prev_error)) * 64'sd1000000) / dt);
                total = saturate32(longint'(error_total) + err);
                error_total = total[31:0];
                prev_error  = err[ERR_W-1:0];
                acc = longint'(gain_p) * err + longint'(gain_i) * total
                    + longint'(gain_d) * slope + longint'(gain_f) * longint'(target_vel);
                acc = acc >>> FRAC_W;
                if (acc > longint'(cmd_ceiling))
                    acc = longint'(cmd_ceiling);
                if (acc < longint'(cmd_floor))
                    acc = longint'(cmd_floor);
                held_cmd = acc[VEL_W-1:0];
                res.updated = 1'b1;
            end
            res.throttle_command = held_cmd;
            expected_commands.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_commands.size() == 0) begin
                $display("%0t unexpected item: command %0d updated %0b",
                         $time, got.throttle_command, got.updated);
                failures++;
                return;
            end
            want = expected_commands.pop_front();
            if (got.throttle_command !== want.throttle_command) begin
                $display("%0t throttle_command mismatch: expected %0d actual %0d",
                         $time, want.throttle_command, got.throttle_command);
                failures++;
            end
            if (got.updated !== want.updated) begin
                $display("%0t updated mismatch: expected %0b actual %0b",
                         $time, want.updated, got.updated);
                failures++;
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VEL_W-1:0]     cfg_data  = '0;

    command_scoreboard sb;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                cycles         = 0;

    pid_feedforward_velocity_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: check accepted items, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic in_item_t make_item(logic [1:0] op, logic [VEL_W-1:0] vel,
                                           logic [DT_W-1:0] dt, logic [STAT_W-1:0] st);
        in_item_t it;
        it.opcode         = op;
        it.velocity_value = vel;
        it.elapsed_us     = dt;
        it.status_code    = st;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            it.opcode = OP_MEASURED;
        else if (pick < 85)
            it.opcode = OP_TARGET;
        else if (pick < 95)
            it.opcode = OP_STATUS;
        else
            it.opcode = OP_UNUSED;
        if ($urandom_range(0, 99) < 70)
            it.velocity_value = VEL_W'($urandom_range(0, 4096) - 2048);
        else
            it.velocity_value = VEL_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 8)
            it.elapsed_us = '0;
        else if (pick < 68)
            it.elapsed_us = DT_W'($urandom_range(1000, 20000));
        else if (pick < 88)
            it.elapsed_us = DT_W'($urandom_range(1, 50));
        else
            it.elapsed_us = DT_W'($urandom_range(0, 1048575));
        // the loop is only shut down on purpose, near the end
        do
            it.status_code = STAT_W'($urandom);
        while (it.status_code == DISABLE_STATUS);
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(it);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // leaves cfg_valid high so that writes can follow back to back
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [VEL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_register(idx, val);
    endtask

    task automatic apply_settings(input logic signed [VEL_W-1:0] kp,
                                  input logic signed [VEL_W-1:0] ki,
                                  input logic signed [VEL_W-1:0] kd,
                                  input logic signed [VEL_W-1:0] kf,
                                  input logic signed [VEL_W-1:0] ceiling,
                                  input logic signed [VEL_W-1:0] floor_val);
        write_register(REG_KP, kp);
        write_register(REG_KI, ki);
        write_register(REG_KD, kd);
        write_register(REG_KF, kf);
        write_register(REG_CEILING, ceiling);
        write_register(REG_FLOOR, floor_val);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at reset settings, no idling
        send_item(make_item(OP_MEASURED, 16'sd0, 20'd10000, 8'sd0));
        send_item(make_item(OP_MEASURED, 16'sh7fff, 20'd1, 8'sd0));
        send_item(make_item(OP_MEASURED, 16'sh8000, 20'hfffff, 8'sh7f));
        send_item(make_item(OP_TARGET, 16'sh7fff, 20'd1, 8'sh80));
        send_item(make_item(OP_TARGET, 16'sh8000, 20'd1, 8'sd0));
        send_item(make_item(OP_MEASURED, 16'sd256, 20'd0, 8'sd0));
        send_item(make_item(OP_TARGET, 16'sd300, 20'd0, 8'sd0));
        send_item(make_item(OP_TARGET, 16'sd512, 20'd1000000, 8'sd0));
        send_item(make_item(OP_MEASURED, -16'sd1, 20'd500, 8'sd0));
        send_item(make_item(OP_MEASURED, 16'sh5555, 20'h55555, 8'sh55));
        send_item(make_item(OP_TARGET, 16'shaaaa, 20'haaaaa, 8'shaa));
        send_item(make_item(OP_STATUS, 16'sh7fff, 20'd10, 8'sh7f));
        send_item(make_item(OP_STATUS, 16'sd0, 20'd0, 8'sh80));
        send_item(make_item(OP_STATUS, 16'sd100, 20'd10000, 8'sd0));
        send_item(make_item(OP_STATUS, 16'sd100, 20'd10000, 8'sd1));
        send_item(make_item(OP_STATUS, 16'sd100, 20'd10000, 8'sd3));
        send_item(make_item(OP_UNUSED, 16'sh8000, 20'hfffff, DISABLE_STATUS));
        send_item(make_item(OP_UNUSED, 16'sd1000, 20'd10000, 8'sd5));
        send_item(make_item(OP_MEASURED, 16'sd512, 20'd10000, 8'sd0));
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    write_register(REG_UNUSED_LO, VEL_W'($urandom));
                    write_register(REG_UNUSED_HI, VEL_W'($urandom));
                    apply_settings(16'sd512, 16'sd16, 16'sd1, 16'sd256,
                                   16'sd25600, -16'sd25600);
                end
                1: apply_settings(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                                  16'sh7fff, 16'sh8000);
                2: apply_settings(16'sd2560, 16'sd64, 16'sd4, 16'sd256,
                                  -16'sd256, 16'sd256);
                3: apply_settings(16'sd0, 16'sd256, 16'sd0, -16'sd256,
                                  16'sh7fff, 16'sh8000);
                4: apply_settings(VEL_W'($urandom), VEL_W'($urandom), VEL_W'($urandom),
                                  VEL_W'($urandom), VEL_W'($urandom), VEL_W'($urandom));
                5: apply_settings(KP_RESET, KI_RESET, KD_RESET, KF_RESET,
                                  CEILING_RESET, FLOOR_RESET);
                6: apply_settings(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                                  16'sh7fff, 16'sh8000);
                default: apply_settings(16'sd1280, 16'sd8, 16'sd2, 16'sd256,
                                        16'sd12800, -16'sd12800);
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // shut the loop down halfway through the last phase
                if (phase == 7 && n == PHASE_ITEMS / 2)
                    send_item(make_item(OP_STATUS, 16'sd0, 20'd10000, DISABLE_STATUS));
                send_item(random_item());
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
